### sv/udpenc_pkg.sv
// Shared types, constants and the ones'-complement fold for the UDP header
// checksum unit. No dependencies.
`timescale 1ns / 1ps

package udpenc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PortW   = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned SumW    = 19;  // six 16-bit terms fit in 19 bits
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PortW-1:0]  DefaultPort = 16'd1234;
  localparam logic [CountW-1:0] CountMax    = '1;
  localparam logic [PortW-1:0]  HeaderBytes = 16'd8;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SRC_PORT = 2'd0,
    CFG_DST_PORT = 2'd1,
    CFG_CKS_EN   = 2'd2
  } cfg_idx_e;

  // One input beat
  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             byte_present;
    logic             end_of_packet;
  } item_t;

  // Live configuration
  typedef struct packed {
    logic [PortW-1:0] src_port;
    logic [PortW-1:0] dst_port;
    logic             cks_en;
  } cfg_t;

  // One header result
  typedef struct packed {
    logic [PortW-1:0] src_port;
    logic [PortW-1:0] dst_port;
    logic [PortW-1:0] udp_len;
    logic [PortW-1:0] cks;
    logic             len_ovf;
  } hdr_t;

  // Fold a wide sum of 16-bit words into a 16-bit ones'-complement sum
  function automatic logic [PortW-1:0] oc_fold(input logic [SumW-1:0] s);
    logic [PortW:0] t;
    t = {1'b0, s[PortW-1:0]} + {{(PortW + 1 - (SumW - PortW)){1'b0}}, s[SumW-1:PortW]};
    return t[PortW-1:0] + {{(PortW-1){1'b0}}, t[PortW]};
  endfunction

endpackage

### sv/udpenc_if.sv
// Channel interfaces of the UDP header checksum unit: payload in, header
// out and configuration writes. Depends on udpenc_pkg.
`timescale 1ns / 1ps

interface udpenc_in_if;
  logic                          valid;
  logic                          ready;
  logic [udpenc_pkg::ByteW-1:0]  payload_byte;
  logic                          byte_present;
  logic                          end_of_packet;

  modport source (output valid, payload_byte, byte_present, end_of_packet, input ready);
  modport sink   (input valid, payload_byte, byte_present, end_of_packet, output ready);
endinterface

interface udpenc_out_if;
  logic                          valid;
  logic                          ready;
  logic [udpenc_pkg::PortW-1:0]  header_source_port;
  logic [udpenc_pkg::PortW-1:0]  header_destination_port;
  logic [udpenc_pkg::PortW-1:0]  udp_length;
  logic [udpenc_pkg::PortW-1:0]  header_checksum;
  logic                          length_overflow;

  modport source (output valid, header_source_port, header_destination_port, udp_length,
                  header_checksum, length_overflow, input ready);
  modport sink   (input valid, header_source_port, header_destination_port, udp_length,
                  header_checksum, length_overflow, output ready);
endinterface

interface udpenc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [udpenc_pkg::CfgIdxW-1:0] reg_index;
  logic [udpenc_pkg::PortW-1:0]   write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

### sv/udpenc_acc.sv
// Per-packet accumulator: running ones'-complement sum, odd byte and byte
// count, plus the header computed from the beat being retired. Uses udpenc_pkg.
`timescale 1ns / 1ps

module udpenc_acc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  udpenc_pkg::item_t  item_i,
  input  logic               adv_i,
  input  udpenc_pkg::cfg_t   cfg_i,
  output udpenc_pkg::hdr_t   hdr_o
);

  logic [udpenc_pkg::PortW-1:0]  sum_q, sum_d;
  logic [udpenc_pkg::ByteW-1:0]  held_q, held_d;
  logic                          odd_q, odd_d;
  logic [udpenc_pkg::CountW-1:0] count_q, count_d;

  logic                          pair_done;
  logic [udpenc_pkg::PortW-1:0]  pair_word;
  logic [udpenc_pkg::PortW-1:0]  pad_word;
  logic [udpenc_pkg::CountW:0]   total_len;
  logic                          len_ovf;
  logic [udpenc_pkg::PortW-1:0]  udp_len;
  logic [udpenc_pkg::SumW-1:0]   hdr_sum;
  logic [udpenc_pkg::PortW-1:0]  hdr_fold;

  // Advance pair and count state with this beat
  always_comb begin
    pair_done = item_i.byte_present && odd_q;
    pair_word = pair_done ? {held_q, item_i.payload_byte} : '0;
    sum_d     = pair_done ? udpenc_pkg::oc_fold({3'b000, sum_q} + {3'b000, pair_word}) : sum_q;
    if (item_i.byte_present) begin
      odd_d  = ~odd_q;
      held_d = odd_q ? '0 : item_i.payload_byte;
    end else begin
      odd_d  = odd_q;
      held_d = held_q;
    end
    if (item_i.byte_present && (count_q != udpenc_pkg::CountMax)) begin
      count_d = count_q + {{(udpenc_pkg::CountW-1){1'b0}}, 1'b1};
    end else begin
      count_d = count_q;
    end
  end

  // Saturate the length field
  always_comb begin
    total_len = {1'b0, count_d} + {{(udpenc_pkg::CountW + 1 - udpenc_pkg::PortW){1'b0}},
                                   udpenc_pkg::HeaderBytes};
    len_ovf   = |total_len[udpenc_pkg::CountW:udpenc_pkg::PortW];
    udp_len   = len_ovf ? '1 : total_len[udpenc_pkg::PortW-1:0];
  end

  // Sum header and payload words in one wide add, then fold
  always_comb begin
    pad_word = odd_d ? {held_d, {udpenc_pkg::ByteW{1'b0}}} : '0;
    hdr_sum  = {3'b000, sum_q} + {3'b000, pair_word} + {3'b000, pad_word}
             + {3'b000, cfg_i.src_port} + {3'b000, cfg_i.dst_port} + {3'b000, udp_len};
    hdr_fold = udpenc_pkg::oc_fold(hdr_sum);

    hdr_o.src_port = cfg_i.src_port;
    hdr_o.dst_port = cfg_i.dst_port;
    hdr_o.udp_len  = udp_len;
    hdr_o.cks      = cfg_i.cks_en ? ~hdr_fold : '0;
    hdr_o.len_ovf  = len_ovf;
  end

  // Hold packet state; clear it when the last beat retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      held_q  <= '0;
      odd_q   <= 1'b0;
      count_q <= '0;
    end else if (adv_i) begin
      if (item_i.end_of_packet) begin
        sum_q   <= '0;
        held_q  <= '0;
        odd_q   <= 1'b0;
        count_q <= '0;
      end else begin
        sum_q   <= sum_d;
        held_q  <= held_d;
        odd_q   <= odd_d;
        count_q <= count_d;
      end
    end
  end

endmodule

### sv/udp_header_checksum_encap_unit.sv
// Top level of the UDP header checksum unit: input register, accumulator,
// header output register and configuration registers. Uses udpenc_pkg,
// udpenc_if and udpenc_acc.
`timescale 1ns / 1ps

// Usage
//   pay_i  : one payload beat per handshake (byte, byte_present, end_of_packet).
//            A beat with byte_present low and end_of_packet high closes the
//            packet with the bytes seen so far.
//   hdr_o  : one header beat per packet (ports, length, checksum, overflow flag),
//            produced by the beat that carries end_of_packet.
//   cfg_i  : register writes: 0 source port, 1 destination port, 2 checksum
//            enable; other indexes are ignored. Write only while idle.
// Throughput is one payload beat per cycle, except while an end-of-packet beat
// waits in the input register for a stalled header to drain.
// An accepted beat waits in the input register until it retires into the
// accumulator; the end-of-packet beat loads the header output register as it retires.
// Reset clears the packet state and both valid flags and loads port 1234 into
// both port registers with the checksum enabled.
// While hdr_o stalls, non-final beats keep flowing; an end-of-packet beat
// waits in the input register and pay_i.ready drops until the header drains.

module udp_header_checksum_encap_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  udpenc_in_if.sink         pay_i,
  udpenc_out_if.source      hdr_o,
  udpenc_cfg_if.sink        cfg_i
);

  logic              s1_valid_q;
  udpenc_pkg::item_t s1_item_q;
  logic              out_valid_q;
  udpenc_pkg::hdr_t  out_hdr_q;
  udpenc_pkg::cfg_t  cfg_q;

  udpenc_pkg::hdr_t  hdr_d;
  logic              out_free;
  logic              s1_adv;
  logic              hdr_load;
  logic              in_ready;

  // Handshake control
  assign out_free = !out_valid_q || hdr_o.ready;
  assign s1_adv   = s1_valid_q && (!s1_item_q.end_of_packet || out_free);
  assign hdr_load = s1_adv && s1_item_q.end_of_packet;
  assign in_ready = !s1_valid_q || s1_adv;

  assign pay_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  // Capture input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= pay_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && pay_i.valid) begin
      s1_item_q.payload_byte  <= pay_i.payload_byte;
      s1_item_q.byte_present  <= pay_i.byte_present;
      s1_item_q.end_of_packet <= pay_i.end_of_packet;
    end
  end

  // Packet accumulator
  udpenc_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (s1_item_q),
    .adv_i  (s1_adv),
    .cfg_i  (cfg_q),
    .hdr_o  (hdr_d)
  );

  // Header output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= hdr_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_load) begin
      out_hdr_q <= hdr_d;
    end
  end

  assign hdr_o.valid                   = out_valid_q;
  assign hdr_o.header_source_port      = out_hdr_q.src_port;
  assign hdr_o.header_destination_port = out_hdr_q.dst_port;
  assign hdr_o.udp_length              = out_hdr_q.udp_len;
  assign hdr_o.header_checksum         = out_hdr_q.cks;
  assign hdr_o.length_overflow         = out_hdr_q.len_ovf;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_port <= udpenc_pkg::DefaultPort;
      cfg_q.dst_port <= udpenc_pkg::DefaultPort;
      cfg_q.cks_en   <= 1'b1;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == udpenc_pkg::CFG_SRC_PORT) begin
        cfg_q.src_port <= cfg_i.write_data;
      end else if (cfg_i.reg_index == udpenc_pkg::CFG_DST_PORT) begin
        cfg_q.dst_port <= cfg_i.write_data;
      end else if (cfg_i.reg_index == udpenc_pkg::CFG_CKS_EN) begin
        cfg_q.cks_en <= cfg_i.write_data[0];
      end
    end
  end

  // Checks
  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_hdr_q.len_ovf) |-> (out_hdr_q.udp_len == '1))
    else $error("overflowed header without saturated length");

  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_hdr_q.udp_len >= udpenc_pkg::HeaderBytes))
    else $error("header length below header size");

  a_cks_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_load && !cfg_q.cks_en) |=> (out_hdr_q.cks == '0))
    else $error("nonzero checksum with checksum disabled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_valid_q && s1_item_q.end_of_packet && out_valid_q && !hdr_o.ready))
    else $error("input stalled without a blocked header");

endmodule
